// ----- hdl/brl_pkg.sv -----
package brl_pkg;

	// Configuration register widths and reset values
	localparam int FW_BITS      = 13;
	localparam int FP_BITS      = 23;
	localparam int CFG_IDX_BITS = 2;
	localparam int CH_BITS      = 8;

	localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(640);
	localparam logic [FP_BITS-1:0] FP_RESET = FP_BITS'(307200);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0),
		CFG_FRAME_PIXELS = CFG_IDX_BITS'(1)
	} cfg_idx_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef struct packed {
		logic [CH_BITS-1:0] red;
		logic [CH_BITS-1:0] green;
		logic [CH_BITS-1:0] blue;
	} color_t;

endpackage

// ----- hdl/brl_if.sv -----
// Command channel: one start or step item per handshake
interface brl_cmd_if
	import brl_pkg::*;
#(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [CH_BITS-1:0]           color_red_in;
	logic [CH_BITS-1:0]           color_green_in;
	logic [CH_BITS-1:0]           color_blue_in;

	modport source (output valid, op, start_x, start_y, end_x, end_y,
		color_red_in, color_green_in, color_blue_in, input ready);
	modport sink (input valid, op, start_x, start_y, end_x, end_y,
		color_red_in, color_green_in, color_blue_in, output ready);
	modport mon (input valid, ready, op, start_x, start_y, end_x, end_y,
		color_red_in, color_green_in, color_blue_in);
endinterface

// Pixel channel: one pixel write per handshake
interface brl_pix_if
	import brl_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int ADDR_BITS  = 22
);
	logic                         valid;
	logic                         ready;
	logic                         produced;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic [ADDR_BITS-1:0]         write_address;
	logic                         write_enable;
	logic [CH_BITS-1:0]           pixel_red;
	logic [CH_BITS-1:0]           pixel_green;
	logic [CH_BITS-1:0]           pixel_blue;
	logic                         last;

	modport source (output valid, produced, pixel_x, pixel_y, write_address,
		write_enable, pixel_red, pixel_green, pixel_blue, last, input ready);
	modport sink (input valid, produced, pixel_x, pixel_y, write_address,
		write_enable, pixel_red, pixel_green, pixel_blue, last, output ready);
	modport mon (input valid, ready, produced, pixel_x, pixel_y, write_address,
		write_enable, pixel_red, pixel_green, pixel_blue, last);
endinterface

// Configuration write channel
interface brl_cfg_if
	import brl_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [FP_BITS-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport mon (input valid, ready, index, data);
endinterface

// ----- hdl/bresenham_line_rasterizer_unit.sv -----
// A pixel passes through stages 1, 2 and 3 after its command item is taken.
// Throughput: one item per cycle unless pix stalls; the step loop (error add,
// compare, coordinate move) closes on the line state registers, and the
// address multiply and clip compare follow in two registered stages.
// Reset (arst_n low, asynchronous): line idle, state cleared, pipeline empty,
// frame_width = 640, frame_pixels = 307200.
module bresenham_line_rasterizer_unit
	import brl_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int ADDR_BITS  = 22
) (
	input  logic      clk,
	input  logic      arst_n,
	brl_cfg_if.sink   cfg,
	brl_cmd_if.sink   cmd,
	brl_pix_if.source pix
);

	localparam int C     = COORD_BITS;
	localparam int PRODW = FW_BITS + 1 + C;
	localparam int MAXA  = (PRODW > ADDR_BITS) ? PRODW : ADDR_BITS;
	localparam int SUMW  = ((MAXA > FP_BITS) ? MAXA : FP_BITS) + 1;
	localparam int XW    = ((C > FW_BITS) ? C : FW_BITS) + 1;

	// Configuration registers
	logic [FW_BITS-1:0] frame_width_q;
	logic [FP_BITS-1:0] frame_pixels_q;

	// Writes are always taken; an index beyond the list is dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_pixels_q <= FP_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg.data[FW_BITS-1:0];
				CFG_FRAME_PIXELS: frame_pixels_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Line state
	logic [C-1:0] cur_x_q, cur_y_q;
	logic [C:0]   err_acc_q;
	logic [C-1:0] dist_x_abs_q, dist_y_abs_q;
	logic [1:0]   step_x_sign_q, step_y_sign_q;
	logic         x_is_major_q;
	logic [C-1:0] steps_left_q;
	color_t       line_color_q;
	logic         line_active_q;

	// Pipeline stage valids and flow control
	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;
	logic cmd_acc;

	// Each stage moves when the one after it is empty or moving
	assign en_s3   = !v_s3 || pix.ready;
	assign en_s2   = !v_s2 || en_s3;
	assign en_s1   = !v_s1 || en_s2;
	assign cmd.ready = en_s1;
	assign cmd_acc = cmd.valid && en_s1;

	// Next-state logic for start and step
	logic [C:0]   dx, dy;
	logic [C-1:0] dxa, dya, major_st;
	logic         xmaj_st;
	logic [C-1:0] minor_sp, major_sp;
	logic [C:0]   err_sum, err_sp;
	logic         take_sp, move_x, move_y;
	logic [C-1:0] x_sp, y_sp, steps_sp;

	logic [C-1:0] nx_x, nx_y, nx_dxa, nx_dya, nx_steps;
	logic [C:0]   nx_err;
	logic [1:0]   nx_sx, nx_sy;
	logic         nx_xmaj, nx_active, nx_emit, nx_last;
	color_t       nx_color;

	always_comb begin
		// Start: endpoint differences in one extra bit
		dx       = {cmd.end_x[C-1], cmd.end_x} - {cmd.start_x[C-1], cmd.start_x};
		dy       = {cmd.end_y[C-1], cmd.end_y} - {cmd.start_y[C-1], cmd.start_y};
		dxa      = dx[C] ? C'(-dx) : dx[C-1:0];
		dya      = dy[C] ? C'(-dy) : dy[C-1:0];
		xmaj_st  = dxa >= dya;
		major_st = xmaj_st ? dxa : dya;

		// Step: grow the error by the minor distance, move minor on overflow
		minor_sp = x_is_major_q ? dist_y_abs_q : dist_x_abs_q;
		major_sp = x_is_major_q ? dist_x_abs_q : dist_y_abs_q;
		err_sum  = err_acc_q + {1'b0, minor_sp};
		take_sp  = err_sum >= {1'b0, major_sp};
		err_sp   = take_sp ? (err_sum - {1'b0, major_sp}) : err_sum;
		move_x   = x_is_major_q || take_sp;
		move_y   = !x_is_major_q || take_sp;
		x_sp     = move_x ? (cur_x_q + {{(C-2){step_x_sign_q[1]}}, step_x_sign_q}) : cur_x_q;
		y_sp     = move_y ? (cur_y_q + {{(C-2){step_y_sign_q[1]}}, step_y_sign_q}) : cur_y_q;
		steps_sp = steps_left_q - C'(1);

		// Hold everything by default
		nx_x      = cur_x_q;
		nx_y      = cur_y_q;
		nx_err    = err_acc_q;
		nx_dxa    = dist_x_abs_q;
		nx_dya    = dist_y_abs_q;
		nx_sx     = step_x_sign_q;
		nx_sy     = step_y_sign_q;
		nx_xmaj   = x_is_major_q;
		nx_steps  = steps_left_q;
		nx_color  = line_color_q;
		nx_active = line_active_q;
		nx_emit   = 1'b0;

		unique case (op_t'(cmd.op))
			OP_START: begin
				// Drop any line in flight and begin the new one
				nx_x      = cmd.start_x;
				nx_y      = cmd.start_y;
				nx_dxa    = dxa;
				nx_dya    = dya;
				nx_sx     = (dx == '0) ? 2'b00 : (dx[C] ? 2'b11 : 2'b01);
				nx_sy     = (dy == '0) ? 2'b00 : (dy[C] ? 2'b11 : 2'b01);
				nx_xmaj   = xmaj_st;
				nx_err    = {1'b0, major_st} >> 1;
				nx_steps  = major_st;
				nx_color  = '{red: cmd.color_red_in, green: cmd.color_green_in,
					blue: cmd.color_blue_in};
				nx_active = major_st != '0;
				nx_emit   = 1'b1;
			end
			OP_STEP: begin
				// A step with no line running leaves the state alone
				if (line_active_q) begin
					nx_x      = x_sp;
					nx_y      = y_sp;
					nx_err    = err_sp;
					nx_steps  = steps_sp;
					nx_active = steps_sp != '0;
					nx_emit   = 1'b1;
				end
			end
			default: ;
		endcase

		nx_last = !nx_active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			err_acc_q     <= '0;
			dist_x_abs_q  <= '0;
			dist_y_abs_q  <= '0;
			step_x_sign_q <= '0;
			step_y_sign_q <= '0;
			x_is_major_q  <= 1'b0;
			steps_left_q  <= '0;
			line_color_q  <= '0;
			line_active_q <= 1'b0;
		end else if (cmd_acc) begin
			cur_x_q       <= nx_x;
			cur_y_q       <= nx_y;
			err_acc_q     <= nx_err;
			dist_x_abs_q  <= nx_dxa;
			dist_y_abs_q  <= nx_dya;
			step_x_sign_q <= nx_sx;
			step_y_sign_q <= nx_sy;
			x_is_major_q  <= nx_xmaj;
			steps_left_q  <= nx_steps;
			line_color_q  <= nx_color;
			line_active_q <= nx_active;
		end
	end

	// Stage 1: the pixel just stepped to
	logic signed [C-1:0] x_s1, y_s1;
	color_t              color_s1;
	logic                last_s1;

	// Stage 2: row offset product, and a flag for x in range and y not negative
	logic signed [C-1:0]     x_s2, y_s2;
	color_t                  color_s2;
	logic                    last_s2;
	logic signed [PRODW-1:0] prod_s2;
	logic                    inside_s2;

	// Stage 3: output register
	logic signed [C-1:0]  x_s3, y_s3;
	color_t               color_s3;
	logic                 last_s3;
	logic [ADDR_BITS-1:0] addr_s3;
	logic                 we_s3;

	logic signed [PRODW-1:0] prod_c;
	logic                    inside_c;
	logic [SUMW-1:0]         sum_c;
	logic                    we_c;

	always_comb begin
		prod_c   = PRODW'($signed({1'b0, frame_width_q})) * PRODW'(y_s1);
		inside_c = !x_s1[C-1] && !y_s1[C-1]
			&& ({{(XW-C){1'b0}}, x_s1} < {{(XW-FW_BITS){1'b0}}, frame_width_q});

		// Full address; the top bits show whether it fits the address space
		sum_c = {{(SUMW-PRODW){prod_s2[PRODW-1]}}, prod_s2}
			+ {{(SUMW-C){x_s2[C-1]}}, x_s2};
		we_c  = inside_s2
			&& (sum_c < {{(SUMW-FP_BITS){1'b0}}, frame_pixels_q})
			&& (sum_c[SUMW-1:ADDR_BITS] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= cmd_acc && nx_emit;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Payload registers carry no reset
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1     <= nx_x;
			y_s1     <= nx_y;
			color_s1 <= nx_color;
			last_s1  <= nx_last;
		end
		if (en_s2) begin
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			color_s2  <= color_s1;
			last_s2   <= last_s1;
			prod_s2   <= prod_c;
			inside_s2 <= inside_c;
		end
		if (en_s3) begin
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			color_s3 <= color_s2;
			last_s3  <= last_s2;
			addr_s3  <= sum_c[ADDR_BITS-1:0];
			we_s3    <= we_c;
		end
	end

	assign pix.valid         = v_s3;
	assign pix.produced      = 1'b1;
	assign pix.pixel_x       = x_s3;
	assign pix.pixel_y       = y_s3;
	assign pix.write_address = addr_s3;
	assign pix.write_enable  = we_s3;
	assign pix.pixel_red     = color_s3.red;
	assign pix.pixel_green   = color_s3.green;
	assign pix.pixel_blue    = color_s3.blue;
	assign pix.last          = last_s3;

endmodule

// ----- hdl/brl_checker.sv -----
module brl_checker #(
	parameter int COORD_BITS = 16,
	parameter int ADDR_BITS  = 22
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_ready,
	input logic                         pix_valid,
	input logic                         pix_ready,
	input logic                         pix_produced,
	input logic signed [COORD_BITS-1:0] pix_x,
	input logic signed [COORD_BITS-1:0] pix_y,
	input logic [ADDR_BITS-1:0]         pix_addr,
	input logic                         pix_we,
	input logic                         pix_last
);

	// A stalled pixel holds its payload
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix_x)
			&& $stable(pix_y) && $stable(pix_addr)
			&& $stable(pix_we) && $stable(pix_last))
		else $error("pixel payload changed while stalled");

	// Enabled writes never land at negative coordinates
	a_we_coords: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_we |-> !pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1])
		else $error("write enabled on a negative coordinate");

	// Every pixel shown is a produced one
	a_produced: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> pix_produced)
		else $error("pixel shown without produced");

	// Command items are held back only by a stalled pixel
	a_cmd_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> pix_valid && !pix_ready)
		else $error("command held back with the pixel channel free");

	// Nothing leaves during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !pix_valid)
		else $error("pixel valid during reset");

endmodule

bind bresenham_line_rasterizer_unit brl_checker #(
	.COORD_BITS(COORD_BITS),
	.ADDR_BITS (ADDR_BITS)
) u_brl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_ready    (cmd.ready),
	.pix_valid    (pix.valid),
	.pix_ready    (pix.ready),
	.pix_produced (pix.produced),
	.pix_x        (pix.pixel_x),
	.pix_y        (pix.pixel_y),
	.pix_addr     (pix.write_address),
	.pix_we       (pix.write_enable),
	.pix_last     (pix.last)
);
